/* rtl/rmr_pkg.sv */
// rmr_pkg: shared constants for the rational multiply and reduce block.
// No dependencies; used by rtl/rational_multiply_reduce.sv.
package rmr_pkg;

	// Default width of one signed operand field
	localparam int VALUE_WIDTH_DEF = 32;

endpackage

/* rtl/rational_multiply_reduce.sv */
// rational_multiply_reduce: product of two signed rationals, reduced to lowest terms.
// Depends on rmr_pkg for the default operand width.
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------------------
// input    | in        | in_valid / in_ready | left/right numerator and denominator (signed)
// result   | out       | out_valid/out_ready | status, result_numerator, result_denominator
//
// One transaction at a time: in_ready is high only while the sequencer is idle.
// A zero denominator goes straight to the result and a zero numerator does so after both products;
// otherwise the sequencer strips common factors of two, runs the binary gcd on the 2*VALUE_WIDTH-bit
// products and divides both by the gcd. One multiplier, one subtractor.
// A result held off by out_ready stalls the sequencer in its last state.
// Reset clears the sequencer and the output valid flag; datapath registers are not reset.
module rational_multiply_reduce #(
	parameter int VALUE_WIDTH = rmr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] left_numerator,
	input  logic signed [VALUE_WIDTH-1:0] left_denominator,
	input  logic signed [VALUE_WIDTH-1:0] right_numerator,
	input  logic signed [VALUE_WIDTH-1:0] right_denominator,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic signed [VALUE_WIDTH-1:0] result_numerator,
	output logic        [VALUE_WIDTH-2:0] result_denominator
);

	localparam int W  = VALUE_WIDTH;
	localparam int DW = 2 * W;
	localparam int CW = $clog2(DW);
	localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);
	localparam logic [DW-1:0] SIGN_MAG = DW'(64'd1 << (W - 1));
	localparam logic [DW-1:0] MAX_POS  = DW'((64'd1 << (W - 1)) - 64'd1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_N = 3'd1;
	localparam logic [2:0] ST_MUL_D = 3'd2;
	localparam logic [2:0] ST_EVEN  = 3'd3;
	localparam logic [2:0] ST_GCD   = 3'd4;
	localparam logic [2:0] ST_DIV_N = 3'd5;
	localparam logic [2:0] ST_DIV_D = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// Unsigned magnitude of a two's complement field; the most negative value maps to 2^(W-1)
	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	logic [2:0]    state_q;
	logic          out_valid_q;
	logic          err_q, zero_q, neg_q;
	logic [DW-1:0] num_q, den_q;   // products, then reduced values
	logic [DW-1:0] a_q, b_q;       // operand magnitudes, gcd pair, quotient shifter / gcd
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          status_q;
	logic [W-1:0]  res_num_q;
	logic [W-2:0]  res_den_q;

	logic          in_acc, fin_go;
	logic [W-1:0]  mul_x, mul_y;
	logic [DW-1:0] mul_p;
	logic [DW:0]   sub_x, sub_y, sub_d;
	logic [DW:0]   rem_sh;
	logic [DW-1:0] quo_nx;
	logic          zero_den;
	logic          ovf;
	logic [DW-1:0] num_neg;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status             = status_q;
	assign result_numerator   = res_num_q;
	assign result_denominator = res_den_q;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign zero_den  = (left_denominator == '0) || (right_denominator == '0);

	// Shared multiplier: numerator pair first, denominator pair next
	always_comb begin
		if (state_q == ST_MUL_N) begin
			mul_x = a_q[DW-1:W];
			mul_y = a_q[W-1:0];
		end else begin
			mul_x = b_q[DW-1:W];
			mul_y = b_q[W-1:0];
		end
	end
	assign mul_p = DW'(mul_x) * DW'(mul_y);

	// Shared subtractor: a - b in the gcd loop, shifted remainder - gcd in the divisions
	assign rem_sh = {rem_q, a_q[DW-1]};
	always_comb begin
		if (state_q == ST_GCD) begin
			sub_x = {1'b0, a_q};
		end else begin
			sub_x = rem_sh;
		end
		sub_y = {1'b0, b_q};
	end
	assign sub_d  = sub_x - sub_y;
	assign quo_nx = {a_q[DW-2:0], ~sub_d[DW]};

	// Range check and sign restore on the reduced pair
	assign ovf     = (den_q > MAX_POS) || (neg_q ? (num_q > SIGN_MAG) : (num_q > MAX_POS));
	assign num_neg = ~num_q + DW'(1);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (in_acc) state_q <= zero_den ? ST_FIN : ST_MUL_N;
				ST_MUL_N: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= (num_q == '0) ? ST_FIN : ST_EVEN;
				ST_EVEN:  if (num_q[0] || den_q[0]) state_q <= ST_GCD;
				ST_GCD:   if (a_q == '0) state_q <= ST_DIV_N;
				ST_DIV_N: if (cnt_q == CNT_LAST) state_q <= ST_DIV_D;
				ST_DIV_D: if (cnt_q == CNT_LAST) state_q <= ST_FIN;
				ST_FIN:   if (fin_go) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					a_q    <= {mag_of(left_numerator), mag_of(right_numerator)};
					b_q    <= {mag_of(left_denominator), mag_of(right_denominator)};
					err_q  <= zero_den;
					zero_q <= 1'b0;
					neg_q  <= left_numerator[W-1] ^ left_denominator[W-1]
						^ right_numerator[W-1] ^ right_denominator[W-1];
				end
			end
			ST_MUL_N: num_q <= mul_p;
			ST_MUL_D: begin
				den_q  <= mul_p;
				zero_q <= (num_q == '0);
			end
			// Strip common factors of two from both products
			ST_EVEN: begin
				if (!num_q[0] && !den_q[0]) begin
					num_q <= num_q >> 1;
					den_q <= den_q >> 1;
				end else begin
					a_q <= num_q;
					b_q <= den_q;
				end
			end
			// Binary gcd; at least one of the pair is odd, so the gcd is odd
			ST_GCD: begin
				priority if (a_q == '0) begin
					a_q   <= num_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (sub_d[DW]) begin
					a_q <= b_q;
					b_q <= a_q;
				end else begin
					a_q <= sub_d[DW-1:0];
				end
			end
			// Restoring division by the gcd in b_q, one quotient bit a cycle
			ST_DIV_N, ST_DIV_D: begin
				if (cnt_q == CNT_LAST) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == ST_DIV_N) begin
						num_q <= quo_nx;
						a_q   <= den_q;
					end else begin
						den_q <= quo_nx;
					end
				end else begin
					rem_q <= sub_d[DW] ? rem_sh[DW-1:0] : sub_d[DW-1:0];
					cnt_q <= cnt_q + CW'(1);
					a_q   <= quo_nx;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					priority if (err_q) begin
						status_q  <= 1'b1;
						res_num_q <= '0;
						res_den_q <= '0;
					end else if (zero_q) begin
						status_q  <= 1'b0;
						res_num_q <= '0;
						res_den_q <= (W-1)'(1);
					end else if (ovf) begin
						status_q  <= 1'b1;
						res_num_q <= '0;
						res_den_q <= '0;
					end else begin
						status_q  <= 1'b0;
						res_num_q <= neg_q ? num_neg[W-1:0] : num_q[W-1:0];
						res_den_q <= den_q[W-2:0];
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// gcd loop never works against a zero divisor
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (b_q != '0))
		else $error("gcd divisor is zero");

	// after stripping common twos the gcd is odd
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_N || state_q == ST_DIV_D) |-> b_q[0])
		else $error("gcd is even during division");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_N || state_q == ST_DIV_D) |-> (rem_q < b_q))
		else $error("division remainder out of bound");

	// an accepted transaction holds off the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while busy");

	// a good result always has a positive denominator
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |-> (result_denominator != '0))
		else $error("zero denominator on good result");
`endif

endmodule

/* bench/rmr_checker.sv */
// rmr_checker: watches both channels of rational_multiply_reduce, predicts each reduced
// product and compares it field by field with what the block returns.
// Depends on rmr_pkg for the operand width.
module rmr_checker #(
	parameter int VW = rmr_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [VW-1:0] left_numerator,
	input  logic signed [VW-1:0] left_denominator,
	input  logic signed [VW-1:0] right_numerator,
	input  logic signed [VW-1:0] right_denominator,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 status,
	input  logic signed [VW-1:0] result_numerator,
	input  logic        [VW-2:0] result_denominator,
	output int                   mismatch_count,
	output int                   products_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] VW_MASK   = (64'd1 << VW) - 64'd1;
	localparam bit [63:0] VW_SIGN   = 64'd1 << (VW - 1);
	localparam bit [63:0] VW_MAXPOS = VW_SIGN - 64'd1;

	typedef struct {
		bit          flag;
		bit [VW-1:0] num;
		bit [VW-2:0] den;
	} product_t;

	product_t expected_products[$];
	product_t want;
	int       fail_tally = 0;
	int       open_tally = 0;

	assign mismatch_count   = fail_tally;
	assign products_pending = open_tally;

	// magnitude of a two's complement operand, sign returned separately
	function automatic bit [63:0] operand_magnitude(input bit [VW-1:0] raw, output bit neg);
		bit [63:0] v;
		v = '0;
		v[VW-1:0] = raw;
		neg = raw[VW-1];
		if (neg)
			return (~v + 64'd1) & VW_MASK;
		return v;
	endfunction

	// exact product of both rationals, divided down by the Euclidean gcd
	function automatic product_t reduce_product(input bit [VW-1:0] ln, input bit [VW-1:0] ld,
			input bit [VW-1:0] rn, input bit [VW-1:0] rd);
		bit        sln, sld, srn, srd, neg;
		bit [63:0] mln, mld, mrn, mrd, pn, pd, x, y, r, g, signed_num;
		product_t  p;
		p.flag = 1'b1;
		p.num  = '0;
		p.den  = '0;
		mln = operand_magnitude(ln, sln);
		mld = operand_magnitude(ld, sld);
		mrn = operand_magnitude(rn, srn);
		mrd = operand_magnitude(rd, srd);
		if (mld == 64'd0 || mrd == 64'd0)
			return p;
		pn  = mln * mrn;
		pd  = mld * mrd;
		neg = (sln != srn) != (sld != srd);
		if (pn == 64'd0)
			neg = 1'b0;
		x = pn;
		y = pd;
		while (y != 64'd0) begin
			r = x % y;
			x = y;
			y = r;
		end
		g  = (x == 64'd0) ? 64'd1 : x;
		pn = pn / g;
		pd = pd / g;
		if (pd > VW_MAXPOS)
			return p;
		if (neg ? (pn > VW_SIGN) : (pn > VW_MAXPOS))
			return p;
		signed_num = neg ? (64'd0 - pn) : pn;
		p.flag = 1'b0;
		p.num  = signed_num[VW-1:0];
		p.den  = pd[VW-2:0];
		return p;
	endfunction

	// results are retired before the same edge's new transaction is queued
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_products.size() == 0) begin
					$error("result with no transaction outstanding: status %0d num %0d den %0d",
						status, result_numerator, result_denominator);
					fail_tally++;
				end else begin
					want = expected_products.pop_front();
					open_tally--;
					if (status !== want.flag) begin
						$error("status: expected %0d, got %0d", want.flag, status);
						fail_tally++;
					end
					if (result_numerator !== want.num) begin
						$error("result_numerator: expected %0d, got %0d",
							$signed(want.num), result_numerator);
						fail_tally++;
					end
					if (result_denominator !== want.den) begin
						$error("result_denominator: expected %0d, got %0d",
							want.den, result_denominator);
						fail_tally++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_products.push_back(reduce_product(left_numerator, left_denominator,
					right_numerator, right_denominator));
				open_tally++;
			end
		end
	end

endmodule

/* bench/tb.sv */
// tb: drives operand pairs into rational_multiply_reduce with random gaps and output stalls.
// Depends on rmr_pkg, the block itself and bench/rmr_checker.sv, which does all checking.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW             = rmr_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_ITEMS   = 930;
	localparam int LONG_HOLD      = 3000;
	localparam int HOLD_AT        = 300;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 500;

	localparam logic signed [VW-1:0] OPERAND_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] OPERAND_MAX = {1'b0, {(VW-1){1'b1}}};

	typedef enum int {FIELD_FULL, FIELD_SMALL, FIELD_EXTREME} field_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [VW-1:0] left_numerator = '0;
	logic signed [VW-1:0] left_denominator = '0;
	logic signed [VW-1:0] right_numerator = '0;
	logic signed [VW-1:0] right_denominator = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 status;
	logic signed [VW-1:0] result_numerator;
	logic        [VW-2:0] result_denominator;
	int                   mismatch_count;
	int                   products_pending;
	int                   sent_count = 0;
	int                   taken_count = 0;
	int                   quiet_cycles = 0;

	rational_multiply_reduce #(.VALUE_WIDTH(VW)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_numerator(left_numerator), .left_denominator(left_denominator),
		.right_numerator(right_numerator), .right_denominator(right_denominator),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_numerator(result_numerator),
		.result_denominator(result_denominator)
	);

	rmr_checker #(.VW(VW)) product_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_numerator(left_numerator), .left_denominator(left_denominator),
		.right_numerator(right_numerator), .right_denominator(right_denominator),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_numerator(result_numerator),
		.result_denominator(result_denominator),
		.mismatch_count(mismatch_count), .products_pending(products_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one stretch of every four hundred transactions runs without idling
	function automatic bit eager_phase(input int n);
		return ((n / 100) % 4) == 2;
	endfunction

	function automatic logic signed [VW-1:0] draw_field(input field_kind_t kind);
		int pick;
		case (kind)
			FIELD_SMALL: begin
				return $signed($urandom_range(0, 2000)) - 1000;
			end
			FIELD_EXTREME: begin
				pick = $urandom_range(0, 6);
				case (pick)
					0: return OPERAND_MIN;
					1: return OPERAND_MAX;
					2: return -1;
					3: return 0;
					4: return 1;
					5: return OPERAND_MIN + 1;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// offer one transaction at a falling edge and hold it until accepted
	task automatic send_operands(input logic signed [VW-1:0] ln, input logic signed [VW-1:0] ld,
			input logic signed [VW-1:0] rn, input logic signed [VW-1:0] rd);
		int gap;
		gap = eager_phase(sent_count) ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid          <= 1'b1;
		left_numerator    <= ln;
		left_denominator  <= ld;
		right_numerator   <= rn;
		right_denominator <= rd;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	task automatic send_random;
		int                   mode, k, a, b, c, d;
		logic signed [VW-1:0] ln, ld, rn, rd;
		mode = $urandom_range(0, 99);
		if (mode < 35) begin
			ln = draw_field(FIELD_FULL);
			ld = draw_field(FIELD_FULL);
			rn = draw_field(FIELD_FULL);
			rd = draw_field(FIELD_FULL);
		end else if (mode < 65) begin
			ln = draw_field(FIELD_SMALL);
			ld = draw_field(FIELD_SMALL);
			rn = draw_field(FIELD_SMALL);
			rd = draw_field(FIELD_SMALL);
		end else if (mode < 85) begin
			// shared factor across the operands so the gcd has real work
			k = $urandom_range(1, 5000);
			a = $urandom_range(1, 5000);
			b = $urandom_range(1, 5000);
			c = $urandom_range(1, 5000);
			d = $urandom_range(1, 5000);
			if ($urandom_range(0, 1)) a = -a;
			if ($urandom_range(0, 1)) b = -b;
			if ($urandom_range(0, 1)) c = -c;
			if ($urandom_range(0, 1)) d = -d;
			if ($urandom_range(0, 1)) begin
				ln = a * k; ld = b; rn = c; rd = d * k;
			end else begin
				ln = a; ld = b * k; rn = c * k; rd = d;
			end
		end else if (mode < 93) begin
			ln = draw_field(FIELD_EXTREME);
			ld = draw_field(FIELD_EXTREME);
			rn = draw_field(FIELD_EXTREME);
			rd = draw_field(FIELD_EXTREME);
		end else begin
			// a zero numerator or denominator somewhere
			ln = draw_field(FIELD_FULL);
			ld = draw_field(FIELD_FULL);
			rn = draw_field(FIELD_FULL);
			rd = draw_field(FIELD_FULL);
			case ($urandom_range(0, 3))
				0: ln = 0;
				1: rn = 0;
				2: ld = 0;
				default: rd = 0;
			endcase
		end
		send_operands(ln, ld, rn, rd);
	endtask

	// stimulus and verdict
	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// zero denominators
		send_operands(0, 0, 0, 0);
		send_operands(5, 0, 3, 7);
		send_operands(5, 7, 3, 0);
		send_operands(OPERAND_MIN, 0, OPERAND_MAX, 0);
		// zero numerators with negative signs around
		send_operands(0, -3, 7, 5);
		send_operands(-4, 9, 0, -2);
		// reduction and sign handling
		send_operands(6, 4, 2, 3);
		send_operands(-6, 4, 2, -3);
		send_operands(12, -35, 49, 18);
		send_operands(-1, -1, -1, -1);
		// range edges of the reduced numerator
		send_operands(OPERAND_MAX, 1, OPERAND_MAX, 1);
		send_operands(OPERAND_MIN, 1, 1, 1);
		send_operands(OPERAND_MIN, 1, -1, 1);
		send_operands(OPERAND_MIN, -1, 1, 1);
		// range edges of the reduced denominator
		send_operands(1, OPERAND_MIN, 1, 1);
		send_operands(-1, OPERAND_MIN, 1, 1);
		send_operands(2, OPERAND_MIN, 1, 1);
		send_operands(1, OPERAND_MAX, 1, 2);
		// extremes that cancel completely
		send_operands(OPERAND_MIN, OPERAND_MIN, OPERAND_MIN, OPERAND_MIN);
		send_operands(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
		send_operands(OPERAND_MAX, 2, 2, OPERAND_MAX);
		send_operands(OPERAND_MAX, OPERAND_MIN, OPERAND_MIN, OPERAND_MAX);
		send_operands(OPERAND_MIN, 3, 3, OPERAND_MIN);

		repeat (RANDOM_ITEMS) send_random();
		@(negedge clk);
		in_valid <= 1'b0;

		while (products_pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && products_pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// result side: random stalls, plus one long hold so the block backs up
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (taken_count == HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = eager_phase(taken_count) ? 0 : $urandom_range(0, 9);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken_count++;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

endmodule
